// ===== sv/nsc_pkg.sv =====
// ----------------------------------------------------------------------------
// nsc_pkg
// Shared constants, types and helpers for the NMEA sentence checksum framer.
// ----------------------------------------------------------------------------
package nsc_pkg;

    localparam logic [7:0] C_CH_DOLLAR = 8'h24;
    localparam logic [7:0] C_CH_STAR   = 8'h2A;
    localparam logic [7:0] C_CH_CR     = 8'h0D;
    localparam logic [7:0] C_CH_LF     = 8'h0A;

    // sentences must be longer than this to produce a result
    localparam int unsigned C_MIN_CLOSE_LEN = 6;

    localparam logic [23:0] C_TAG_GGA = "GGA";
    localparam logic [23:0] C_TAG_RMC = "RMC";

    typedef enum logic [1:0] {
        KIND_OTHER = 2'd0,
        KIND_GGA   = 2'd1,
        KIND_RMC   = 2'd2
    } t_kind;

    typedef struct packed {
        logic        checksum_ok;
        logic        star_found;
        t_kind       sentence_kind;
        logic [7:0]  computed_sum;
        logic [7:0]  received_sum;
        logic [6:0]  sentence_length;
        logic [31:0] valid_count;
    } t_result;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } t_hex;

    function automatic t_hex hex_digit(input logic [7:0] c);
        t_hex h;
        h.ok    = 1'b1;
        h.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.value = 4'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.value = 4'(c - 8'h41 + 8'd10);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.value = 4'(c - 8'h61 + 8'd10);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

// ===== sv/nsc_parser.sv =====
// ----------------------------------------------------------------------------
// nsc_parser
// Sentence framing state and checksum tracking, one byte per cycle.
// ----------------------------------------------------------------------------
module nsc_parser #(
    parameter int BUFFER_BYTES = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_byte_vld,
    input  logic [7:0]         i_byte,
    output logic               o_emit,
    output nsc_pkg::t_result   o_result
);
    import nsc_pkg::*;

    localparam int PW = $clog2(BUFFER_BYTES);

    logic [PW-1:0] r_pos, n_pos;
    logic [7:0]    r_xor, n_xor;
    logic [7:0]    r_xor_star, n_xor_star;
    logic          r_star, n_star;
    logic [1:0]    r_after, n_after;
    logic [7:0]    r_hex, n_hex;
    logic          r_hex_open, n_hex_open;
    logic          r_gga, n_gga;
    logic          r_rmc, n_rmc;
    logic [31:0]   r_cnt, n_cnt;

    t_hex       w_hd;
    logic       w_found;
    logic       w_ok;
    logic [7:0] w_csum;
    logic [7:0] w_gga_ch;
    logic [7:0] w_rmc_ch;
    logic       w_in_tag;

    assign w_hd    = hex_digit(i_byte);
    assign w_found = r_star && (r_after == 2'd2);
    assign w_csum  = r_star ? r_xor_star : r_xor;
    assign w_ok    = w_found && (w_csum == r_hex);

    // type tag lives in sentence bytes 3..5
    always_comb begin
        w_in_tag = 1'b1;
        w_gga_ch = 8'h00;
        w_rmc_ch = 8'h00;
        case (r_pos)
            PW'(3): begin
                w_gga_ch = C_TAG_GGA[23:16];
                w_rmc_ch = C_TAG_RMC[23:16];
            end
            PW'(4): begin
                w_gga_ch = C_TAG_GGA[15:8];
                w_rmc_ch = C_TAG_RMC[15:8];
            end
            PW'(5): begin
                w_gga_ch = C_TAG_GGA[7:0];
                w_rmc_ch = C_TAG_RMC[7:0];
            end
            default: w_in_tag = 1'b0;
        endcase
    end

    always_comb begin
        n_pos      = r_pos;
        n_xor      = r_xor;
        n_xor_star = r_xor_star;
        n_star     = r_star;
        n_after    = r_after;
        n_hex      = r_hex;
        n_hex_open = r_hex_open;
        n_gga      = r_gga;
        n_rmc      = r_rmc;
        n_cnt      = r_cnt;
        o_emit     = 1'b0;

        if (i_byte_vld) begin
            if (i_byte == C_CH_DOLLAR) begin
                n_pos      = PW'(1);
                n_xor      = 8'h00;
                n_xor_star = 8'h00;
                n_star     = 1'b0;
                n_after    = 2'd0;
                n_hex      = 8'h00;
                n_hex_open = 1'b0;
                n_gga      = 1'b1;
                n_rmc      = 1'b1;
            end else if (r_pos != '0) begin
                if (i_byte == C_CH_CR || i_byte == C_CH_LF) begin
                    n_pos = '0;
                    if (r_pos > PW'(C_MIN_CLOSE_LEN)) begin
                        o_emit = 1'b1;
                        if (w_ok) begin
                            n_cnt = r_cnt + 32'd1;
                        end
                    end
                end else if (r_pos >= PW'(BUFFER_BYTES - 1)) begin
                    // overrun, sentence dropped
                    n_pos = '0;
                end else begin
                    if (w_in_tag) begin
                        if (i_byte != w_gga_ch) n_gga = 1'b0;
                        if (i_byte != w_rmc_ch) n_rmc = 1'b0;
                    end
                    if (i_byte == C_CH_STAR) begin
                        n_xor_star = r_xor;
                        n_star     = 1'b1;
                        n_after    = 2'd0;
                        n_hex      = 8'h00;
                        n_hex_open = 1'b1;
                    end else if (r_star) begin
                        if (r_after != 2'd2) n_after = r_after + 2'd1;
                        if (r_hex_open) begin
                            if (w_hd.ok) begin
                                n_hex = {r_hex[3:0], w_hd.value};
                            end else begin
                                n_hex_open = 1'b0;
                            end
                        end
                    end
                    n_xor = r_xor ^ i_byte;
                    n_pos = r_pos + PW'(1);
                end
            end
        end
    end

    always_comb begin
        o_result.checksum_ok     = w_ok;
        o_result.star_found      = w_found;
        o_result.sentence_kind   = r_gga ? KIND_GGA : (r_rmc ? KIND_RMC : KIND_OTHER);
        o_result.computed_sum    = w_csum;
        o_result.received_sum    = r_hex;
        o_result.sentence_length = 7'(r_pos);
        o_result.valid_count     = w_ok ? r_cnt + 32'd1 : r_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_xor      <= 8'h00;
            r_xor_star <= 8'h00;
            r_star     <= 1'b0;
            r_after    <= 2'd0;
            r_hex      <= 8'h00;
            r_hex_open <= 1'b0;
            r_gga      <= 1'b1;
            r_rmc      <= 1'b1;
            r_cnt      <= 32'd0;
        end else begin
            r_pos      <= n_pos;
            r_xor      <= n_xor;
            r_xor_star <= n_xor_star;
            r_star     <= n_star;
            r_after    <= n_after;
            r_hex      <= n_hex;
            r_hex_open <= n_hex_open;
            r_gga      <= n_gga;
            r_rmc      <= n_rmc;
            r_cnt      <= n_cnt;
        end
    end

endmodule

// ===== sv/nsc_out_reg.sv =====
// ----------------------------------------------------------------------------
// nsc_out_reg
// Result register with valid/stall handshake toward the consumer.
// ----------------------------------------------------------------------------
module nsc_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  nsc_pkg::t_result i_result,
    output logic             o_free,
    output logic             o_valid,
    input  logic             i_stall,
    output nsc_pkg::t_result o_result
);
    import nsc_pkg::*;

    logic    r_vld;
    t_result r_res;

    // free when empty or the held word leaves this cycle
    assign o_free   = !r_vld || !i_stall;
    assign o_valid  = r_vld;
    assign o_result = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_load) begin
            r_vld <= 1'b1;
        end else if (!i_stall) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_result;
        end
    end

endmodule

// ===== sv/nmea_sentence_checksum_framer.sv =====
// ----------------------------------------------------------------------------
// nmea_sentence_checksum_framer
// Frames an NMEA 0183 byte stream into sentences and checks their checksums.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle, back to back; a byte is registered in the
// input register, then runs through the framing/checksum logic, and a sentence
// result is loaded into the output register when its closing CR or LF is
// processed. A new byte is accepted every cycle unless the output register is
// full and stalled. '$' opens or restarts a sentence; sentences of 7 or more
// bytes give one result word, shorter ones and those that reach BUFFER_BYTES
// are dropped.
module nmea_sentence_checksum_framer #(
    parameter int BUFFER_BYTES = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_checksum_ok,
    output logic        o_star_found,
    output logic [1:0]  o_sentence_kind,
    output logic [7:0]  o_computed_sum,
    output logic [7:0]  o_received_sum,
    output logic [6:0]  o_sentence_length,
    output logic [31:0] o_valid_count
);
    import nsc_pkg::*;

    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       w_free;
    logic       w_advance;
    logic       w_emit;
    t_result    w_res;
    t_result    w_out;

    assign w_advance = r_in_vld && w_free;
    assign o_stall   = r_in_vld && !w_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_stall) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte <= i_rx_byte;
        end
    end

    nsc_parser #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_byte_vld (w_advance),
        .i_byte     (r_in_byte),
        .o_emit     (w_emit),
        .o_result   (w_res)
    );

    nsc_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_advance && w_emit),
        .i_result (w_res),
        .o_free   (w_free),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (w_out)
    );

    assign o_checksum_ok     = w_out.checksum_ok;
    assign o_star_found      = w_out.star_found;
    assign o_sentence_kind   = w_out.sentence_kind;
    assign o_computed_sum    = w_out.computed_sum;
    assign o_received_sum    = w_out.received_sum;
    assign o_sentence_length = w_out.sentence_length;
    assign o_valid_count     = w_out.valid_count;

endmodule
